// ===== sv/ecpd_pkg.sv =====
// Shared types and constants for secp256k1 point decompression.
package ecpd_pkg;

    localparam int unsigned FW = 256;
    localparam int unsigned LW = 32;
    localparam int unsigned NL = FW / LW;
    localparam int unsigned LIDX_W = $clog2(NL);
    localparam int unsigned WIDX_W = LIDX_W + 1;

    localparam logic [FW-1:0] PRIME =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
    localparam logic [FW-1:0] ROOT_EXP =
        256'h3FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_BFFFFF0C;
    // 2^256 = 2^32 + 977 mod p
    localparam logic [9:0] FOLD_MUL = 10'd977;
    localparam logic [7:0] PREFIX_EVEN = 8'h02;
    localparam logic [7:0] PREFIX_ODD  = 8'h03;
    localparam logic [FW-1:0] CURVE_B = 256'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_XSQ,
        S_XCUBE,
        S_ADDB,
        S_SQR,
        S_MULA,
        S_VERIFY,
        S_FIX,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PROD,
        M_TEST,
        M_FOLD,
        M_RED
    } t_mstate;

endpackage

// ===== sv/ecpd_modmul.sv =====
// Multicycle modular multiplier mod p: one 32x32 limb product per cycle, then limb-serial fold.
module ecpd_modmul
    import ecpd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [FW-1:0] i_a,
    input  logic [FW-1:0] i_b,
    output logic          o_done,
    output logic [FW-1:0] o_r
);

    t_mstate              r_st, n_st;
    logic [LIDX_W-1:0]    r_i, n_i;
    logic [LIDX_W-1:0]    r_j, n_j;
    logic [WIDX_W-1:0]    r_k, n_k;
    logic [LW-1:0]        r_cy, n_cy;
    logic [LW-1:0]        r_w [2*NL];
    logic [FW-1:0]        r_a, r_b;
    logic [LW-1:0]        a_limb, b_limb;
    logic [WIDX_W-1:0]    w_idx;
    logic [2*LW-1:0]      mac;
    logic [LW-1:0]        f_lo, f_hi, f_prev;
    logic [LW+11:0]       facc;
    logic [FW-1:0]        low;
    logic                 hi_nz;
    logic [FW:0]          diff;

    assign a_limb = r_a[r_i*LW +: LW];
    assign b_limb = r_b[r_j*LW +: LW];
    assign w_idx  = {1'b0, r_i} + {1'b0, r_j};
    assign mac    = a_limb * b_limb + {{LW{1'b0}}, r_w[w_idx]} + {{LW{1'b0}}, r_cy};

    // fold step k: w[k] = cy + w[k] + w[k+8]*977 + w[k+7]
    assign f_lo   = r_k[LIDX_W] ? '0 : r_w[r_k];
    assign f_hi   = r_k[LIDX_W] ? '0 : r_w[{1'b1, r_k[LIDX_W-1:0]}];
    assign f_prev = (r_k == '0) ? '0 : r_w[r_k + WIDX_W'(NL - 1)];
    assign facc   = {12'd0, r_cy} + {12'd0, f_lo} + {12'd0, f_prev} + f_hi * FOLD_MUL;

    always_comb begin
        hi_nz = 1'b0;
        for (int n = 0; n < NL; n++) begin
            low[n*LW +: LW] = r_w[n];
            hi_nz = hi_nz | (r_w[NL + n] != '0);
        end
    end

    assign diff = {1'b0, low} - {1'b0, PRIME};

    always_comb begin
        n_st = r_st;
        n_i  = r_i;
        n_j  = r_j;
        n_k  = r_k;
        n_cy = r_cy;
        unique case (r_st)
            M_IDLE: begin
                if (i_go) begin
                    n_st = M_PROD;
                    n_i  = '0;
                    n_j  = '0;
                    n_cy = '0;
                end
            end
            M_PROD: begin
                if (r_j == LIDX_W'(NL - 1)) begin
                    n_cy = '0;
                    n_j  = '0;
                    n_i  = r_i + 1'b1;
                    if (r_i == LIDX_W'(NL - 1)) n_st = M_TEST;
                end else begin
                    n_cy = mac[2*LW-1:LW];
                    n_j  = r_j + 1'b1;
                end
            end
            M_TEST: begin
                if (hi_nz) begin
                    n_st = M_FOLD;
                    n_k  = '0;
                    n_cy = '0;
                end else begin
                    n_st = M_RED;
                end
            end
            M_FOLD: begin
                n_cy = LW'(facc[LW+11:LW]);
                n_k  = r_k + 1'b1;
                if (r_k == WIDX_W'(NL)) n_st = M_TEST;
            end
            M_RED:   n_st = M_IDLE;
            default: n_st = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
            r_i  <= '0;
            r_j  <= '0;
            r_k  <= '0;
            r_cy <= '0;
        end else begin
            r_st <= n_st;
            r_i  <= n_i;
            r_j  <= n_j;
            r_k  <= n_k;
            r_cy <= n_cy;
        end
        if (r_st == M_IDLE && i_go) begin
            r_a <= i_a;
            r_b <= i_b;
            for (int n = 0; n < 2*NL; n++) r_w[n] <= '0;
        end else if (r_st == M_PROD) begin
            r_w[w_idx] <= mac[LW-1:0];
            // last limb of a row: the carry lands in the next free word
            if (r_j == LIDX_W'(NL - 1)) r_w[{1'b1, r_i}] <= mac[2*LW-1:LW];
        end else if (r_st == M_FOLD) begin
            r_w[r_k] <= facc[LW-1:0];
            if (r_k == WIDX_W'(NL)) begin
                r_w[NL + 1] <= LW'(facc[LW+11:LW]);
                for (int n = NL + 2; n < 2*NL; n++) r_w[n] <= '0;
            end
        end
    end

    assign o_done = (r_st == M_RED);
    assign o_r    = diff[FW] ? low : diff[FW-1:0];

endmodule

// ===== sv/ec_point_decompress_top.sv =====
// Top level: compressed secp256k1 key to affine point via a shared modular multiplier.
// Sequence: one modular multiply runs its limb products, then fold passes until the high words
// are zero; a good prefix with X < p runs 506 of them (x^2, x^3, the square-and-multiply root
// and a verify square); a bad prefix or X >= p goes from the check straight to the strobe.
// Throughput: one key at a time; busy drops the cycle after the strobe; receiver cannot stall.
// Synchronous active-low reset returns the sequencer and the multiplier to idle.
module ec_point_decompress_top
    import ecpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_key_prefix,
    input  logic [63:0] i_x_word_3,
    input  logic [63:0] i_x_word_2,
    input  logic [63:0] i_x_word_1,
    input  logic [63:0] i_x_word_0,
    output logic        o_done,
    output logic        o_point_valid,
    output logic [63:0] o_out_x_3,
    output logic [63:0] o_out_x_2,
    output logic [63:0] o_out_x_1,
    output logic [63:0] o_out_x_0,
    output logic [63:0] o_out_y_3,
    output logic [63:0] o_out_y_2,
    output logic [63:0] o_out_y_1,
    output logic [63:0] o_out_y_0
);

    t_state         r_st, n_st;
    logic [7:0]     r_bit, n_bit;
    logic [7:0]     r_pre;
    logic [FW-1:0]  r_x, r_alpha, r_y;
    logic           r_ok;
    logic           r_busy_mm;
    logic           mm_go, mm_done;
    logic [FW-1:0]  mm_a, mm_b, mm_r;
    logic [FW:0]    sum_b;
    logic [FW-1:0]  alpha_n;
    logic           chk_ok;

    ecpd_modmul u_mm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (mm_go),
        .i_a    (mm_a),
        .i_b    (mm_b),
        .o_done (mm_done),
        .o_r    (mm_r)
    );

    assign chk_ok  = (r_pre == PREFIX_EVEN || r_pre == PREFIX_ODD) && (r_x < PRIME);
    assign sum_b   = {1'b0, r_alpha} + {1'b0, CURVE_B};
    assign alpha_n = (sum_b >= {1'b0, PRIME}) ? FW'(sum_b - {1'b0, PRIME}) : sum_b[FW-1:0];

    // next state
    always_comb begin
        n_st  = r_st;
        n_bit = r_bit;
        unique case (r_st)
            S_IDLE:  if (start) n_st = S_CHECK;
            S_CHECK: n_st = chk_ok ? S_XSQ : S_DONE;
            S_XSQ:   if (mm_done) n_st = S_XCUBE;
            S_XCUBE: if (mm_done) n_st = S_ADDB;
            S_ADDB: begin
                n_st  = S_SQR;
                n_bit = 8'd255;
            end
            S_SQR: begin
                if (mm_done) begin
                    if (ROOT_EXP[r_bit]) n_st = S_MULA;
                    else if (r_bit == 8'd0) n_st = S_VERIFY;
                    else n_bit = r_bit - 8'd1;
                end
            end
            S_MULA: begin
                if (mm_done) begin
                    if (r_bit == 8'd0) n_st = S_VERIFY;
                    else begin
                        n_st  = S_SQR;
                        n_bit = r_bit - 8'd1;
                    end
                end
            end
            S_VERIFY: if (mm_done) n_st = S_FIX;
            S_FIX:    n_st = S_DONE;
            S_DONE:   n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    // multiplier operands and launch
    always_comb begin
        mm_a = r_y;
        mm_b = r_y;
        unique case (r_st)
            S_XSQ: begin
                mm_a = r_x;
                mm_b = r_x;
            end
            S_XCUBE: begin
                mm_a = r_alpha;
                mm_b = r_x;
            end
            S_MULA:  mm_b = r_alpha;
            default: ;
        endcase
        mm_go = !r_busy_mm && (r_st == S_XSQ || r_st == S_XCUBE || r_st == S_SQR
                               || r_st == S_MULA || r_st == S_VERIFY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_bit     <= '0;
            r_busy_mm <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_bit <= n_bit;
            if (mm_done) r_busy_mm <= 1'b0;
            else if (mm_go) r_busy_mm <= 1'b1;
        end
        unique case (r_st)
            S_IDLE: begin
                if (start) begin
                    r_pre <= i_key_prefix;
                    r_x   <= {i_x_word_3, i_x_word_2, i_x_word_1, i_x_word_0};
                end
                r_ok <= 1'b0;
            end
            S_CHECK: begin
                r_ok <= chk_ok;
                r_y  <= FW'(1);
            end
            S_XSQ:   if (mm_done) r_alpha <= mm_r;
            S_XCUBE: if (mm_done) r_alpha <= mm_r;
            S_ADDB:  r_alpha <= alpha_n;
            S_SQR, S_MULA: if (mm_done) r_y <= mm_r;
            S_VERIFY: if (mm_done && mm_r != r_alpha) r_ok <= 1'b0;
            S_FIX: begin
                // take the root of matching parity; zero stays zero
                if ((r_y[0] ^ r_pre[0]) && (r_y != '0)) r_y <= PRIME - r_y;
            end
            default: ;
        endcase
    end

    assign busy          = (r_st != S_IDLE);
    assign o_done        = (r_st == S_DONE);
    assign o_point_valid = r_ok;
    assign o_out_x_3 = r_ok ? r_x[255:192] : '0;
    assign o_out_x_2 = r_ok ? r_x[191:128] : '0;
    assign o_out_x_1 = r_ok ? r_x[127:64]  : '0;
    assign o_out_x_0 = r_ok ? r_x[63:0]    : '0;
    assign o_out_y_3 = r_ok ? r_y[255:192] : '0;
    assign o_out_y_2 = r_ok ? r_y[191:128] : '0;
    assign o_out_y_1 = r_ok ? r_y[127:64]  : '0;
    assign o_out_y_0 = r_ok ? r_y[63:0]    : '0;

endmodule
